>>> hw/rtl/bpa_pkg.sv
// bpa_pkg: shared constants, codes and helpers for the bitmap page allocator.
// No dependencies; used by bpa_map_ram and bitmap_page_allocator_unit.
package bpa_pkg;

  // map words are fixed at 32 pages each
  localparam int WORD_W    = 32;
  localparam int WORD_BITS = 5;

  // operation codes (func field)
  localparam logic [1:0] FUNC_REGION = 2'd0;
  localparam logic [1:0] FUNC_ALLOC  = 2'd1;
  localparam logic [1:0] FUNC_FREE   = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  typedef struct packed {
    logic                 hit;
    logic [WORD_BITS-1:0] idx;
  } zero_find_t;

  // lowest clear bit of a map word
  function automatic zero_find_t find_lowest_zero(input logic [WORD_W-1:0] w);
    zero_find_t r;
    r.hit = ~&w;
    r.idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r.idx = WORD_BITS'(i);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bpa_map_ram.sv
// bpa_map_ram: used-page bitmap storage, one 32-bit word per entry.
// One write port, one registered read port. Depends on bpa_pkg.
module bpa_map_ram #(
  parameter int WORDS = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic [AW-1:0]             rd_addr,
  output logic [bpa_pkg::WORD_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bpa_pkg::WORD_W-1:0] wr_data
);

  logic [bpa_pkg::WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/bitmap_page_allocator_unit.sv
// bitmap_page_allocator_unit: bitmap page allocator top level; needs bpa_pkg, bpa_map_ram.
// Alloc: one map word scanned per cycle (WORDS = PAGE_COUNT/32 rounded up); free and
// region clear bits by read-modify-write of each covered word, and an out-of-range
// free skips the map. One word in flight; the next is taken once the result
// is parked in the output register.
// Reset: synchronous; a sweep sets every map bit, no input until done; base -> 0.
module bitmap_page_allocator_unit #(
  parameter int PAGE_COUNT = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic         clk,
  input  logic         rst,
  // input words
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] func, [33:2] region_base, [65:34] region_length,
  // [97:66] region_type, [129:98] page_address, [135:130] zero
  input  logic [135:0] s_tdata,
  // result words
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] alloc_address, [33:32] status, [39:34] zero
  output logic [39:0]  m_tdata,
  // base address register
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  localparam int WW    = bpa_pkg::WORD_W;
  localparam int WB    = bpa_pkg::WORD_BITS;
  localparam int WORDS = (PAGE_COUNT + WW - 1) / WW;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PIW   = AW + WB;   // page index: word, bit

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_MOD_RD = 6'b001000,
    ST_MOD_WR = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t state;

  // input fields
  logic [1:0]  in_func;
  logic [31:0] in_rbase, in_rlen, in_rtype, in_paddr;
  assign in_func  = s_tdata[1:0];
  assign in_rbase = s_tdata[33:2];
  assign in_rlen  = s_tdata[65:34];
  assign in_rtype = s_tdata[97:66];
  assign in_paddr = s_tdata[129:98];

  logic [31:0] page0_addr;

  // sequencer registers
  logic [AW-1:0]  init_idx;
  logic [AW:0]    scan_idx;
  logic           scan_dv;     // rd_data holds word prev_idx
  logic [AW-1:0]  prev_idx;
  logic [PIW-1:0] first_pg, last_pg;   // inclusive page span to clear
  logic [AW-1:0]  cur_word;
  logic           res_alloc;
  logic [PIW-1:0] res_page;
  logic [1:0]     res_status;
  logic [31:0]    out_addr;
  logic [1:0]     out_status;

  // RAM ports
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] rd_data, wr_data;
  logic          wr_en;

  bpa_map_ram #(.WORDS(WORDS), .AW(AW)) u_map (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // accept-cycle decode: region span and free page
  logic [31:0] rg_first, rg_end, rg_clip, fr_page;
  logic        rg_ok, fr_ok;
  always_comb begin
    rg_first = in_rbase >> PAGE_SHIFT;
    rg_end   = (in_rbase + in_rlen) >> PAGE_SHIFT;   // wraps mod 2^32
    rg_clip  = (rg_end > 32'(PAGE_COUNT)) ? 32'(PAGE_COUNT) : rg_end;
    rg_ok    = (in_rtype == 32'd1) && (rg_clip > rg_first);
    fr_page  = (in_paddr - page0_addr) >> PAGE_SHIFT;
    fr_ok    = fr_page < 32'(PAGE_COUNT);
  end

  // scan hit on the word just read
  bpa_pkg::zero_find_t zf;
  assign zf = bpa_pkg::find_lowest_zero(rd_data);

  // clear mask for the word under modification
  logic [WB-1:0] mask_lo, mask_hi;
  logic [WW-1:0] clr_mask;
  logic          last_word;
  always_comb begin
    last_word = (cur_word == last_pg[PIW-1:WB]);
    mask_lo   = (cur_word == first_pg[PIW-1:WB]) ? first_pg[WB-1:0] : '0;
    mask_hi   = last_word ? last_pg[WB-1:0] : WB'(WW - 1);
    for (int b = 0; b < WW; b++) begin
      clr_mask[b] = (WB'(b) >= mask_lo) && (WB'(b) <= mask_hi);
    end
  end

  // RAM port muxing
  always_comb begin
    rd_addr = cur_word;
    wr_en   = 1'b0;
    wr_addr = cur_word;
    wr_data = rd_data & ~clr_mask;
    unique case (state)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_idx;
        wr_data = '1;
      end
      ST_SCAN: begin
        rd_addr = scan_idx[AW-1:0];
        wr_addr = prev_idx;
        wr_data = rd_data | (WW'(1) << zf.idx);
        wr_en   = scan_dv && zf.hit;
      end
      ST_MOD_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_idx   <= '0;
      m_tvalid   <= 1'b0;
      page0_addr <= '0;
      scan_dv    <= 1'b0;
    end else begin
      if (cfg_we) page0_addr <= cfg_wdata;
      // in ST_RESP the output register is reloaded below
      if (m_tvalid && m_tready && state != ST_RESP) m_tvalid <= 1'b0;

      unique case (state)
        ST_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == AW'(WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            res_alloc  <= (in_func == bpa_pkg::FUNC_ALLOC);
            res_status <= (in_func == bpa_pkg::FUNC_FREE && !fr_ok) ?
                          bpa_pkg::STATUS_RANGE : bpa_pkg::STATUS_OK;
            case (in_func)
              bpa_pkg::FUNC_REGION: begin
                first_pg <= rg_first[PIW-1:0];
                last_pg  <= PIW'(rg_clip - 32'd1);
                cur_word <= rg_first[PIW-1:WB];
                state    <= rg_ok ? ST_MOD_RD : ST_RESP;
              end
              bpa_pkg::FUNC_ALLOC: begin
                scan_idx  <= '0;
                scan_dv   <= 1'b0;
                state     <= ST_SCAN;
              end
              bpa_pkg::FUNC_FREE: begin
                first_pg <= fr_page[PIW-1:0];
                last_pg  <= fr_page[PIW-1:0];
                cur_word <= fr_page[PIW-1:WB];
                state    <= fr_ok ? ST_MOD_RD : ST_RESP;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_SCAN: begin
          // one word read per cycle; its data is checked in the next cycle
          if (scan_dv && zf.hit) begin
            res_page <= {prev_idx, zf.idx};
            state    <= ST_RESP;
          end else if (scan_idx == (AW + 1)'(WORDS)) begin
            res_alloc  <= 1'b0;
            res_status <= bpa_pkg::STATUS_NO_FREE;
            state      <= ST_RESP;
          end else begin
            scan_dv  <= 1'b1;
            prev_idx <= scan_idx[AW-1:0];
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_MOD_RD: state <= ST_MOD_WR;
        ST_MOD_WR: begin
          // read-modify-write of cur_word done this cycle
          if (last_word) begin
            state <= ST_RESP;
          end else begin
            cur_word <= cur_word + 1'b1;
            state    <= ST_MOD_RD;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_addr   <= res_alloc ? page0_addr + (32'(res_page) << PAGE_SHIFT) : '0;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_status, out_addr};

endmodule
